// ===== rtl/core/mrq_pkg.sv =====
// Shared types, constants and helper functions for the multilevel ready queue.
`timescale 1ns / 1ps
package mrq_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_PICK   = 2'd1;
	localparam logic [1:0] OP_AGE    = 2'd2;

	localparam logic [1:0] CFG_TICK_AMOUNT   = 2'd0;
	localparam logic [1:0] CFG_AGE_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_AGE_STEP      = 2'd2;

	localparam logic [15:0] TICK_RESET      = 16'd100;
	localparam logic [15:0] THRESHOLD_RESET = 16'd400;
	localparam logic [7:0]  STEP_RESET      = 8'd10;

	localparam logic [7:0] PRIO_CAP = 8'd149;
	localparam logic [7:0] L1_LOW   = 8'd100;
	localparam logic [7:0] L1_END   = 8'd150;
	localparam logic [7:0] L2_LOW   = 8'd50;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_ONE  = 2'd1;
	localparam logic [1:0] LVL_TWO  = 2'd2;
	localparam logic [1:0] LVL_THREE = 2'd3;

	typedef enum logic [2:0] {
		M_INS    = 3'd0,
		M_PICK   = 3'd1,
		M_AGE    = 3'd2,
		M_RANK_I = 3'd3,
		M_RANK_J = 3'd4,
		M_FETCH  = 3'd5
	} mode_t;

	typedef struct packed {
		logic  latch;
		logic  rd_en;
		mode_t mode;
		logic  ins_wr;
		logic  rank_wr;
		logic  respond;
	} cmd_t;

	typedef struct packed {
		logic l3_flag;
	} stat_t;

	function automatic logic [1:0] level_of(input logic [7:0] p);
		logic [1:0] l;
		if (p >= L1_LOW && p < L1_END) l = LVL_ONE;
		else if (p >= L2_LOW && p < L1_LOW) l = LVL_TWO;
		else l = LVL_THREE;
		return l;
	endfunction

	function automatic logic wants_yield(input logic [7:0] cpri, input logic [15:0] cburst,
		input logic [15:0] burst);
		return (cpri < L1_LOW) || (cburst > burst);
	endfunction

endpackage

// ===== rtl/core/mrq_ctrl.sv =====
// Sequencer for the ready queue: slot scans, rank passes and result timing.
`timescale 1ns / 1ps
module mrq_ctrl #(
	parameter int SLOTS = 16,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          opcode,
	output logic                busy,
	output mrq_pkg::cmd_t       cmd,
	output logic [IW-1:0]       addr,
	input  mrq_pkg::stat_t      stat
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SCAN   = 10'b0000000010,
		S_DRAIN  = 10'b0000000100,
		S_INS_WR = 10'b0000001000,
		S_FETCH  = 10'b0000010000,
		S_RI     = 10'b0000100000,
		S_RJ     = 10'b0001000000,
		S_RDRAIN = 10'b0010000000,
		S_RW     = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	state_t        state_q, state_d;
	logic [1:0]    op_q;
	logic [IW-1:0] i_q, j_q, i_d, j_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		cmd = '0;
		cmd.mode = mrq_pkg::M_INS;
		addr = j_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					j_d = '0;
					if (opcode == mrq_pkg::OP_INSERT || opcode == mrq_pkg::OP_PICK ||
						opcode == mrq_pkg::OP_AGE) state_d = S_SCAN;
					else state_d = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				priority if (op_q == mrq_pkg::OP_INSERT) cmd.mode = mrq_pkg::M_INS;
				else if (op_q == mrq_pkg::OP_PICK) cmd.mode = mrq_pkg::M_PICK;
				else cmd.mode = mrq_pkg::M_AGE;
				if (j_q == LAST) state_d = S_DRAIN;
				else j_d = j_q + 1'b1;
			end
			S_DRAIN: begin
				i_d = '0;
				priority if (op_q == mrq_pkg::OP_INSERT) state_d = S_INS_WR;
				else if (op_q == mrq_pkg::OP_PICK) state_d = S_FETCH;
				else state_d = S_RI;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d = S_RESP;
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				cmd.mode = mrq_pkg::M_FETCH;
				state_d = S_RESP;
			end
			S_RI: begin
				addr = i_q;
				if (stat.l3_flag) begin
					cmd.rd_en = 1'b1;
					cmd.mode = mrq_pkg::M_RANK_I;
					j_d = '0;
					state_d = S_RJ;
				end else if (i_q == LAST) begin
					state_d = S_RESP;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			S_RJ: begin
				cmd.rd_en = 1'b1;
				cmd.mode = mrq_pkg::M_RANK_J;
				if (j_q == LAST) state_d = S_RDRAIN;
				else j_d = j_q + 1'b1;
			end
			S_RDRAIN: state_d = S_RW;
			S_RW: begin
				cmd.rank_wr = 1'b1;
				if (i_q == LAST) state_d = S_RESP;
				else begin
					i_d = i_q + 1'b1;
					state_d = S_RI;
				end
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= mrq_pkg::OP_INSERT;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			if (cmd.latch) op_q <= opcode;
		end
	end

endmodule

// ===== rtl/core/mrq_dp.sv =====
// Slot storage, scan compare logic, aging arithmetic and result registers.
`timescale 1ns / 1ps
module mrq_dp #(
	parameter int SLOTS = 16,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	parameter int CW = $clog2(SLOTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mrq_pkg::cmd_t  cmd,
	input  logic [IW-1:0]  addr,
	output mrq_pkg::stat_t stat,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic [1:0]     opcode,
	input  logic [7:0]     thread_id,
	input  logic [7:0]     thread_priority,
	input  logic [15:0]    thread_burst,
	input  logic [15:0]    thread_wait,
	input  logic [7:0]     current_priority,
	input  logic [15:0]    current_burst,
	output logic           done,
	output logic           yield_request,
	output logic           found,
	output logic [7:0]     out_thread_id,
	output logic [7:0]     out_priority,
	output logic [15:0]    out_burst,
	output logic [15:0]    out_wait,
	output logic [1:0]     out_level,
	output logic           table_full
);

	// configuration
	logic [15:0] tick_q, thr_q;
	logic [7:0]  step_q;

	// latched command
	logic [1:0]  op_q;
	logic [7:0]  tid_q, tpri_q, cpri_q;
	logic [15:0] tburst_q, twait_q, cburst_q;

	// slot storage
	logic [7:0]  id_mem [SLOTS];
	logic [7:0]  pri_mem [SLOTS];
	logic [15:0] burst_mem [SLOTS];
	logic [15:0] wait_mem [SLOTS];
	logic [15:0] arr_mem [SLOTS];
	logic [15:0] age_mem [SLOTS];
	logic [7:0]  rd_id, rd_pri;
	logic [15:0] rd_burst, rd_wait, rd_arr, rd_age;

	logic [SLOTS-1:0] valid_q, l3_q;
	logic [15:0]      counter_q;

	logic            proc_s1;
	mrq_pkg::mode_t  mode_s1;
	logic [IW-1:0]   addr_s1;
	logic [IW-1:0]   rd_addr;

	// scan results
	logic          dup_q, free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          h1_q, h2_q, h3_q;
	logic [IW-1:0] b1_idx_q, b2_idx_q, b3_idx_q;
	logic [15:0]   b1_burst_q, b3_age_q;
	logic [7:0]    b1_id_q, b2_id_q;
	logic          yacc_q;
	logic [CW-1:0] cnt_q, rank_q;
	logic [IW-1:0] ri_idx_q;
	logic [15:0]   ri_age_q;

	// combinational helpers
	logic          cur_valid;
	logic [1:0]    cur_lvl, new_lvl;
	logic [16:0]   wsum;
	logic [15:0]   wsat;
	logic [8:0]    psum;
	logic [7:0]    np;
	logic          aged;
	logic [15:0]   pick_age;
	logic [IW-1:0] best_idx;
	logic [1:0]    best_lvl;
	logic          do_ins;
	logic          pick_hit;

	assign stat.l3_flag = l3_q[addr];
	assign cur_valid = valid_q[addr_s1];
	assign cur_lvl = mrq_pkg::level_of(rd_pri);
	assign wsum = {1'b0, rd_wait} + {1'b0, tick_q};
	assign wsat = wsum[16] ? 16'hFFFF : wsum[15:0];
	assign psum = {1'b0, rd_pri} + {1'b0, step_q};
	assign np = (psum > {1'b0, mrq_pkg::PRIO_CAP}) ? mrq_pkg::PRIO_CAP : psum[7:0];
	assign new_lvl = mrq_pkg::level_of(np);
	assign aged = (wsat > thr_q) && (rd_id != 8'd0);
	assign pick_age = counter_q - rd_arr;
	assign do_ins = !dup_q && free_found_q;
	assign pick_hit = (op_q == mrq_pkg::OP_PICK) && (best_lvl != mrq_pkg::LVL_NONE);

	always_comb begin
		priority if (h1_q) begin
			best_idx = b1_idx_q;
			best_lvl = mrq_pkg::LVL_ONE;
		end else if (h2_q) begin
			best_idx = b2_idx_q;
			best_lvl = mrq_pkg::LVL_TWO;
		end else if (h3_q) begin
			best_idx = b3_idx_q;
			best_lvl = mrq_pkg::LVL_THREE;
		end else begin
			best_idx = '0;
			best_lvl = mrq_pkg::LVL_NONE;
		end
	end

	assign rd_addr = (cmd.mode == mrq_pkg::M_FETCH) ? best_idx : addr;

	// registered-read memories
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_id <= id_mem[rd_addr];
			rd_pri <= pri_mem[rd_addr];
			rd_burst <= burst_mem[rd_addr];
			rd_wait <= wait_mem[rd_addr];
			rd_arr <= arr_mem[rd_addr];
			rd_age <= age_mem[rd_addr];
		end
		if (cmd.ins_wr && do_ins) begin
			id_mem[free_idx_q] <= tid_q;
			burst_mem[free_idx_q] <= tburst_q;
		end
		if (cmd.ins_wr && do_ins) begin
			pri_mem[free_idx_q] <= tpri_q;
			wait_mem[free_idx_q] <= twait_q;
		end else if (proc_s1 && mode_s1 == mrq_pkg::M_AGE && cur_valid) begin
			pri_mem[addr_s1] <= aged ? np : rd_pri;
			wait_mem[addr_s1] <= aged ? 16'd0 : wsat;
		end
		if (cmd.ins_wr && do_ins) arr_mem[free_idx_q] <= counter_q;
		else if (cmd.rank_wr) arr_mem[ri_idx_q] <= counter_q + 16'(rank_q);
		if (proc_s1 && mode_s1 == mrq_pkg::M_AGE) age_mem[addr_s1] <= counter_q - rd_arr;
	end

	// latched inputs and scan accumulators
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= opcode;
			tid_q <= thread_id;
			tpri_q <= thread_priority;
			tburst_q <= thread_burst;
			twait_q <= thread_wait;
			cpri_q <= current_priority;
			cburst_q <= current_burst;
			dup_q <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q <= '0;
			h1_q <= 1'b0;
			h2_q <= 1'b0;
			h3_q <= 1'b0;
			yacc_q <= 1'b0;
			cnt_q <= '0;
		end else if (proc_s1) begin
			unique case (mode_s1)
				mrq_pkg::M_INS: begin
					if (cur_valid && rd_id == tid_q) dup_q <= 1'b1;
					if (!cur_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q <= addr_s1;
					end
				end
				mrq_pkg::M_PICK: begin
					if (cur_valid) begin
						unique case (cur_lvl)
							mrq_pkg::LVL_ONE: begin
								if (!h1_q || rd_burst < b1_burst_q ||
									(rd_burst == b1_burst_q && rd_id < b1_id_q)) begin
									h1_q <= 1'b1;
									b1_idx_q <= addr_s1;
									b1_burst_q <= rd_burst;
									b1_id_q <= rd_id;
								end
							end
							mrq_pkg::LVL_TWO: begin
								if (!h2_q || rd_id < b2_id_q) begin
									h2_q <= 1'b1;
									b2_idx_q <= addr_s1;
									b2_id_q <= rd_id;
								end
							end
							default: begin
								if (!h3_q || pick_age > b3_age_q) begin
									h3_q <= 1'b1;
									b3_idx_q <= addr_s1;
									b3_age_q <= pick_age;
								end
							end
						endcase
					end
				end
				mrq_pkg::M_AGE: begin
					if (cur_valid && aged && cur_lvl != mrq_pkg::LVL_ONE) begin
						if (new_lvl == mrq_pkg::LVL_ONE &&
							mrq_pkg::wants_yield(cpri_q, cburst_q, rd_burst)) yacc_q <= 1'b1;
						if (new_lvl == mrq_pkg::LVL_THREE) cnt_q <= cnt_q + 1'b1;
					end
				end
				mrq_pkg::M_RANK_I: begin
					ri_idx_q <= addr_s1;
					ri_age_q <= rd_age;
					rank_q <= '0;
				end
				mrq_pkg::M_RANK_J: begin
					// count refiled entries that were older, or as old and earlier
					if (l3_q[addr_s1] && addr_s1 != ri_idx_q &&
						(rd_age > ri_age_q || (rd_age == ri_age_q && addr_s1 < ri_idx_q)))
						rank_q <= rank_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		proc_s1 <= cmd.rd_en;
		mode_s1 <= cmd.mode;
		addr_s1 <= rd_addr;
		if (proc_s1 && mode_s1 == mrq_pkg::M_AGE)
			l3_q[addr_s1] <= cur_valid && aged && cur_lvl != mrq_pkg::LVL_ONE &&
				new_lvl == mrq_pkg::LVL_THREE;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			priority if (op_q == mrq_pkg::OP_INSERT)
				yield_request <= (mrq_pkg::level_of(tpri_q) == mrq_pkg::LVL_ONE) &&
					mrq_pkg::wants_yield(cpri_q, cburst_q, tburst_q);
			else if (op_q == mrq_pkg::OP_AGE) yield_request <= yacc_q;
			else yield_request <= 1'b0;
			table_full <= (op_q == mrq_pkg::OP_INSERT) && !dup_q && !free_found_q;
			found <= pick_hit;
			out_thread_id <= pick_hit ? rd_id : 8'd0;
			out_priority <= pick_hit ? rd_pri : 8'd0;
			out_burst <= pick_hit ? rd_burst : 16'd0;
			out_wait <= pick_hit ? rd_wait : 16'd0;
			out_level <= pick_hit ? best_lvl : mrq_pkg::LVL_NONE;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			counter_q <= '0;
			done <= 1'b0;
			tick_q <= mrq_pkg::TICK_RESET;
			thr_q <= mrq_pkg::THRESHOLD_RESET;
			step_q <= mrq_pkg::STEP_RESET;
		end else begin
			done <= cmd.respond;
			if (cfg_valid) begin
				unique case (cfg_index)
					mrq_pkg::CFG_TICK_AMOUNT:   tick_q <= cfg_data;
					mrq_pkg::CFG_AGE_THRESHOLD: thr_q <= cfg_data;
					mrq_pkg::CFG_AGE_STEP:      step_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.ins_wr && do_ins) begin
				valid_q[free_idx_q] <= 1'b1;
				counter_q <= counter_q + 16'd1;
			end
			if (cmd.respond && pick_hit)
				valid_q[best_idx] <= 1'b0;
			if (cmd.respond && op_q == mrq_pkg::OP_AGE) counter_q <= counter_q + 16'(cnt_q);
		end
	end

endmodule

// ===== rtl/core/multilevel_ready_queue_with_aging_top.sv =====
// Multilevel ready queue with aging: top level.
`timescale 1ns / 1ps
// Accepts one command when start is high and busy is low; its single result appears on the
// result ports for one cycle with done high, and the receiver cannot stall it. Every insert,
// pick and aging command walks all SLOTS entries through one registered-read port of the slot
// memories. An aging tick follows the walk with a refile check over all SLOTS entries, and
// each entry that drops back into the lowest level adds an ordering pass over all entries.
// Configuration writes are always taken (cfg_ready is high) and must come while idle.
module multilevel_ready_queue_with_aging_top #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  thread_id,
	input  logic [7:0]  thread_priority,
	input  logic [15:0] thread_burst,
	input  logic [15:0] thread_wait,
	input  logic [7:0]  current_priority,
	input  logic [15:0] current_burst,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        yield_request,
	output logic        found,
	output logic [7:0]  out_thread_id,
	output logic [7:0]  out_priority,
	output logic [15:0] out_burst,
	output logic [15:0] out_wait,
	output logic [1:0]  out_level,
	output logic        table_full
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mrq_pkg::cmd_t  cmd;
	mrq_pkg::stat_t stat;
	logic [IW-1:0]  addr;

	assign cfg_ready = 1'b1;

	mrq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (addr),
		.stat   (stat)
	);

	mrq_dp #(.SLOTS(SLOTS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.addr             (addr),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.thread_id        (thread_id),
		.thread_priority  (thread_priority),
		.thread_burst     (thread_burst),
		.thread_wait      (thread_wait),
		.current_priority (current_priority),
		.current_burst    (current_burst),
		.done             (done),
		.yield_request    (yield_request),
		.found            (found),
		.out_thread_id    (out_thread_id),
		.out_priority     (out_priority),
		.out_burst        (out_burst),
		.out_wait         (out_wait),
		.out_level        (out_level),
		.table_full       (table_full)
	);

endmodule

// ===== bench/multilevel_ready_queue_with_aging_top_tb.sv =====
// Self-checking testbench for the multilevel ready queue with aging.
`timescale 1ns / 1ps
module multilevel_ready_queue_with_aging_top_tb;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1630;
	localparam int PHASES = 5;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]  opcode;
		logic [7:0]  thread_id;
		logic [7:0]  thread_priority;
		logic [15:0] thread_burst;
		logic [15:0] thread_wait;
		logic [7:0]  current_priority;
		logic [15:0] current_burst;
	} command_t;

	typedef struct {
		logic        yield_request;
		logic        found;
		logic [7:0]  out_thread_id;
		logic [7:0]  out_priority;
		logic [15:0] out_burst;
		logic [15:0] out_wait;
		logic [1:0]  out_level;
		logic        table_full;
	} response_t;

	class ready_table_model;
		logic        occupied[SLOTS];
		logic [7:0]  ids[SLOTS];
		logic [7:0]  prio[SLOTS];
		logic [15:0] burst[SLOTS];
		logic [15:0] waited[SLOTS];
		logic [15:0] stamp[SLOTS];
		logic [15:0] next_stamp;
		logic [15:0] tick_amount;
		logic [15:0] age_threshold;
		logic [7:0]  age_step;
		response_t   pending[$];
		int          mismatches;
		int          inserts, picks, ticks, others, yields, fulls, hits;

		function void clear();
			for (int i = 0; i < SLOTS; i++) begin
				occupied[i] = 0; ids[i] = 0; prio[i] = 0;
				burst[i] = 0; waited[i] = 0; stamp[i] = 0;
			end
			next_stamp = 0;
			tick_amount = mrq_pkg::TICK_RESET;
			age_threshold = mrq_pkg::THRESHOLD_RESET;
			age_step = mrq_pkg::STEP_RESET;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				mrq_pkg::CFG_TICK_AMOUNT: tick_amount = val;
				mrq_pkg::CFG_AGE_THRESHOLD: age_threshold = val;
				mrq_pkg::CFG_AGE_STEP: age_step = val[7:0];
				default: ;
			endcase
		endfunction

		function logic [1:0] band(logic [7:0] p);
			if (p >= mrq_pkg::L1_LOW && p < mrq_pkg::L1_END) return mrq_pkg::LVL_ONE;
			if (p >= mrq_pkg::L2_LOW && p < mrq_pkg::L1_LOW) return mrq_pkg::LVL_TWO;
			return mrq_pkg::LVL_THREE;
		endfunction

		function void note_command(command_t c);
			response_t r;
			int free_slot, best;
			logic dup;
			logic [16:0] w;
			logic [8:0] np;
			logic [15:0] old_age[SLOTS];
			logic to_l3[SLOTS];
			int rank, moved;
			logic [1:0] old_band;
			r = '{default: 0};
			case (c.opcode)
				mrq_pkg::OP_INSERT: begin
					inserts++;
					if (band(c.thread_priority) == mrq_pkg::LVL_ONE &&
							(c.current_priority < mrq_pkg::L1_LOW ||
							c.current_burst > c.thread_burst))
						r.yield_request = 1;
					free_slot = -1;
					dup = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (occupied[i]) begin
							if (ids[i] == c.thread_id) dup = 1;
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					if (!dup && free_slot < 0) r.table_full = 1;
					else if (!dup) begin
						occupied[free_slot] = 1;
						ids[free_slot] = c.thread_id;
						prio[free_slot] = c.thread_priority;
						burst[free_slot] = c.thread_burst;
						waited[free_slot] = c.thread_wait;
						stamp[free_slot] = next_stamp;
						next_stamp++;
					end
				end
				mrq_pkg::OP_PICK: begin
					picks++;
					best = -1;
					for (int lv = 1; lv <= 3 && best < 0; lv++) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (!occupied[i] || band(prio[i]) != lv) continue;
							if (best < 0) best = i;
							else if (lv == 1) begin
								if (burst[i] < burst[best] ||
										(burst[i] == burst[best] && ids[i] < ids[best]))
									best = i;
							end else if (lv == 2) begin
								if (ids[i] < ids[best]) best = i;
							end else if (16'(next_stamp - stamp[i]) >
									16'(next_stamp - stamp[best])) begin
								best = i;
							end
						end
						if (best >= 0) begin
							r.found = 1;
							r.out_thread_id = ids[best];
							r.out_priority = prio[best];
							r.out_burst = burst[best];
							r.out_wait = waited[best];
							r.out_level = 2'(lv);
							occupied[best] = 0;
							hits++;
						end
					end
				end
				mrq_pkg::OP_AGE: begin
					ticks++;
					for (int i = 0; i < SLOTS; i++) begin
						to_l3[i] = 0;
						old_age[i] = next_stamp - stamp[i];
						if (!occupied[i]) continue;
						w = {1'b0, waited[i]} + {1'b0, tick_amount};
						if (w > 17'h0FFFF) w = 17'h0FFFF;
						waited[i] = w[15:0];
						if (w > {1'b0, age_threshold} && ids[i] > 0) begin
							old_band = band(prio[i]);
							np = {1'b0, prio[i]} + {1'b0, age_step};
							if (np > {1'b0, mrq_pkg::PRIO_CAP}) np = {1'b0, mrq_pkg::PRIO_CAP};
							prio[i] = np[7:0];
							waited[i] = 0;
							if (old_band != mrq_pkg::LVL_ONE) begin
								if (band(prio[i]) == mrq_pkg::LVL_ONE) begin
									if (c.current_priority < mrq_pkg::L1_LOW ||
											c.current_burst > burst[i])
										r.yield_request = 1;
								end else if (band(prio[i]) == mrq_pkg::LVL_THREE) begin
									to_l3[i] = 1;
								end
							end
						end
					end
					moved = 0;
					// refiled entries keep their former FIFO order
					for (int i = 0; i < SLOTS; i++) begin
						if (!to_l3[i]) continue;
						rank = 0;
						for (int j = 0; j < SLOTS; j++)
							if (j != i && to_l3[j] &&
									(old_age[j] > old_age[i] || (old_age[j] == old_age[i] && j < i)))
								rank++;
						stamp[i] = next_stamp + 16'(rank);
						moved++;
					end
					next_stamp += 16'(moved);
				end
				default: others++;
			endcase
			yields += r.yield_request;
			fulls += r.table_full;
			pending.push_back(r);
		endfunction

		function void compare(string name, logic [15:0] expected, logic [15:0] actual);
			if (expected !== actual) begin
				$error("%s: expected %0d, got %0d", name, expected, actual);
				mismatches++;
			end
		endfunction

		function void check_result(response_t a);
			response_t e;
			if (pending.size() == 0) begin
				$error("result with no command outstanding");
				mismatches++;
				return;
			end
			e = pending.pop_front();
			compare("yield_request", 16'(e.yield_request), 16'(a.yield_request));
			compare("found", 16'(e.found), 16'(a.found));
			compare("out_thread_id", 16'(e.out_thread_id), 16'(a.out_thread_id));
			compare("out_priority", 16'(e.out_priority), 16'(a.out_priority));
			compare("out_burst", e.out_burst, a.out_burst);
			compare("out_wait", e.out_wait, a.out_wait);
			compare("out_level", 16'(e.out_level), 16'(a.out_level));
			compare("table_full", 16'(e.table_full), 16'(a.table_full));
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [1:0] opcode, cfg_index, out_level;
	logic [7:0] thread_id, thread_priority, current_priority, out_thread_id, out_priority;
	logic [15:0] thread_burst, thread_wait, current_burst, cfg_data, out_burst, out_wait;
	logic yield_request, found, table_full;

	ready_table_model sched = new();
	int idle_cycles;

	multilevel_ready_queue_with_aging_top #(.SLOTS(SLOTS)) dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// check every result and watch for a stalled block
	always @(posedge clk) begin
		if (done)
			sched.check_result('{yield_request, found, out_thread_id, out_priority,
				out_burst, out_wait, out_level, table_full});
		if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic issue(command_t c, int gap);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		opcode <= c.opcode;
		thread_id <= c.thread_id;
		thread_priority <= c.thread_priority;
		thread_burst <= c.thread_burst;
		thread_wait <= c.thread_wait;
		current_priority <= c.current_priority;
		current_burst <= c.current_burst;
		do @(posedge clk); while (busy);
		sched.note_command(c);
	endtask

	task automatic drain();
		start <= 0;
		while (sched.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// hold valid across back-to-back writes; the caller drops it after the last one
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sched.write_reg(idx, val);
	endtask

	function automatic command_t ins(logic [7:0] id, logic [7:0] p, logic [15:0] b,
		logic [15:0] w, logic [7:0] cp, logic [15:0] cb);
		return '{mrq_pkg::OP_INSERT, id, p, b, w, cp, cb};
	endfunction

	function automatic command_t random_command(int insert_weight);
		command_t c;
		int r;
		r = $urandom_range(0, 99);
		c.opcode = r < insert_weight ? mrq_pkg::OP_INSERT :
			r < insert_weight + (92 - insert_weight) * 6 / 10 ? mrq_pkg::OP_PICK :
			r < 96 ? mrq_pkg::OP_AGE : OP_UNKNOWN;
		c.thread_id = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 24));
		case ($urandom_range(0, 4))
			0: c.thread_priority = 8'($urandom_range(100, 149));
			1: c.thread_priority = 8'($urandom_range(50, 99));
			2: c.thread_priority = 8'($urandom_range(0, 49));
			3: c.thread_priority = 8'($urandom_range(150, 255));
			default: c.thread_priority = 8'($urandom_range(0, 149));
		endcase
		c.thread_burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom);
		c.thread_wait = $urandom_range(0, 1) ? 16'($urandom_range(0, 600)) : 16'($urandom);
		c.current_priority = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 149));
		c.current_burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom);
		return c;
	endfunction

	initial begin
		logic [15:0] ticks_cfg[PHASES] = '{16'd100, 16'd1, 16'd65535, 16'd300, 16'd7};
		logic [15:0] thresh_cfg[PHASES] = '{16'd400, 16'd0, 16'd65535, 16'd1000, 16'd20};
		logic [15:0] step_cfg[PHASES] = '{16'd10, 16'd0, 16'd149, 16'd149, 16'd55};
		command_t directed[$];
		int weight;
		sched.clear();
		idle_cycles = 0;
		arst_n <= 0;
		start <= 0;
		cfg_valid <= 0;
		cfg_index <= mrq_pkg::CFG_TICK_AMOUNT;
		cfg_data <= 0;
		opcode <= mrq_pkg::OP_INSERT;
		thread_id <= 0; thread_priority <= 0; thread_burst <= 0; thread_wait <= 0;
		current_priority <= 0; current_burst <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// extremes, level boundaries, yield cases, duplicates, id zero, saturation
		directed = '{
			ins(8'd0, 8'd149, 16'd0, 16'hFFFF, 8'd0, 16'd0),
			ins(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF),
			ins(8'd255, 8'd100, 16'd5, 16'd0, 8'd149, 16'd0),
			ins(8'd7, 8'd100, 16'd5, 16'd0, 8'd149, 16'd0),
			ins(8'd8, 8'd100, 16'd5, 16'd0, 8'd149, 16'd6),
			ins(8'd9, 8'd99, 16'd5, 16'd399, 8'd99, 16'd0),
			ins(8'd10, 8'd50, 16'd5, 16'd0, 8'd0, 16'd0),
			ins(8'd11, 8'd49, 16'd5, 16'd380, 8'd0, 16'd0),
			ins(8'd12, 8'd0, 16'd5, 16'd0, 8'd0, 16'd0),
			ins(8'd13, 8'd150, 16'd5, 16'd0, 8'd0, 16'd0),
			'{mrq_pkg::OP_AGE, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_AGE, 8'd0, 8'd0, 16'd0, 16'd0, 8'd149, 16'hFFFF},
			'{OP_UNKNOWN, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0},
			'{mrq_pkg::OP_PICK, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0}
		};
		foreach (directed[k]) issue(directed[k], k % 3);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(mrq_pkg::CFG_TICK_AMOUNT, ticks_cfg[ph]);
			write_reg(mrq_pkg::CFG_AGE_THRESHOLD, thresh_cfg[ph]);
			write_reg(mrq_pkg::CFG_AGE_STEP, step_cfg[ph]);
			cfg_valid <= 0;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				// alternate filling and emptying so the table reaches full and empty
				weight = (n / 40) % 2 ? 62 : 35;
				issue(random_command(weight), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8));
			end
		end
		drain();

		$display("ran %0d inserts, %0d picks (%0d found), %0d aging ticks, %0d other codes",
			sched.inserts, sched.picks, sched.hits, sched.ticks, sched.others);
		$display("saw %0d yield requests and %0d full-table drops over %0d register settings",
			sched.yields, sched.fulls, PHASES);
		if (sched.mismatches == 0 && sched.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
